// ----- rtl/positional_list_engine_assert.svh -----
// Assertion macros for the positional list engine.
// Included by the RTL files that carry concurrent checks; no dependencies.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define PLE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional list engine: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define PLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional list engine: next-cycle check failed");

`endif

// ----- rtl/plist_pkg.sv -----
// Shared types and constants for the positional list engine.
// No dependencies; used by the channel interfaces, cells, segments and top level.
`default_nettype none

package plist_pkg;

   // Field widths of the request and response items
   localparam int unsigned KIND_W    = 3;
   localparam int unsigned POS_W     = 7;
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned COUNT_W   = 7;

   // Default list capacity and number of cells between read bus registers
   localparam int unsigned CAPACITY_DEF = 64;
   localparam int unsigned SEG_LEN      = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT    = 3'd0,
      KIND_REMOVE    = 3'd1,
      KIND_READ      = 3'd2,
      KIND_OVERWRITE = 3'd3,
      KIND_CLEAR     = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_POS = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   // Control broadcast to every cell of the chain
   typedef struct packed {
      logic                      shift_up;
      logic                      shift_down;
      logic                      write;
      logic                      read_en;
      logic [POS_W-1:0]          pos;
      logic signed [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/plist_channels.sv -----
// Valid/ready channel interfaces for the request and response items.
// Depends on plist_pkg for field widths.
`default_nettype none

interface plist_req_if;
   logic                                valid;
   logic                                ready;
   logic [plist_pkg::KIND_W-1:0]        kind;
   logic [plist_pkg::POS_W-1:0]         position;
   logic signed [plist_pkg::VALUE_W-1:0] value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

interface plist_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [plist_pkg::VALUE_W-1:0] read_value;
   logic [plist_pkg::STATUS_W-1:0]      status;
   logic [plist_pkg::COUNT_W-1:0]       entry_count;
   logic                                is_empty;

   modport source (output valid, read_value, status, entry_count, is_empty, input ready);
   modport sink   (input valid, read_value, status, entry_count, is_empty, output ready);
endinterface

`default_nettype wire

// ----- rtl/positional_list_engine.sv -----
// Top level of the positional list engine: request decode, count and result register.
// Depends on plist_pkg, plist_channels, plist_seg and the assertion macro header.
//
// Positional list engine. Holds an ordered list of up to CAPACITY signed 32-bit
// entries in a row of cells, one entry per cell. Insert, remove and overwrite act
// on all cells at once: each cell shifts from a neighbor, loads the new value or
// holds; clear only resets the entry count. Requests are handled one at a time. A
// request is taken in the idle state and executed once the response register is
// free. A successful read then sweeps the read bus, which runs through the cells
// and is registered after every eight of them; the sweep waits for the value to
// pass every run register and then loads the result taken from the far end. A new
// request is accepted while the previous result still waits in the response
// register. Entries have no reset; only entries below the entry count are ever read.
`default_nettype none
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
   parameter int unsigned CAPACITY = plist_pkg::CAPACITY_DEF
) (
   input  wire          clock,
   input  wire          reset,
   plist_req_if.sink    req_ch,
   plist_rsp_if.source  rsp_ch
);

   localparam int unsigned NSEG  = (CAPACITY + plist_pkg::SEG_LEN - 1) / plist_pkg::SEG_LEN;
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CW    = (CNT_W > plist_pkg::POS_W) ? CNT_W : plist_pkg::POS_W;
   localparam int unsigned SW_W  = $clog2(NSEG + 1);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_EXEC  = 3'b010,
      S_SWEEP = 3'b100
   } state_type;

   state_type                             state_ff, state_in;
   logic [plist_pkg::KIND_W-1:0]          kind_ff;
   logic [plist_pkg::POS_W-1:0]           pos_ff;
   logic signed [plist_pkg::VALUE_W-1:0]  value_ff;
   logic [CNT_W-1:0]                      count_ff, count_in;
   logic [SW_W-1:0]                       sweep_ff, sweep_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [plist_pkg::VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [plist_pkg::STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]                      rsp_count_ff, rsp_count_in;

   logic                                  req_take;
   logic                                  slot_free;
   logic                                  sweep_done;
   logic                                  load_exec;
   logic                                  load_sweep;
   logic [CW-1:0]                         pos_x;
   logic [CW-1:0]                         cnt_x;
   logic [plist_pkg::STATUS_W-1:0]        status_c;
   logic [CNT_W-1:0]                      count_c;
   logic                                  up_c, down_c, write_c, read_c;
   plist_pkg::cell_ctrl_type              ctrl;

   logic signed [plist_pkg::VALUE_W-1:0]  seg_first [NSEG];
   logic signed [plist_pkg::VALUE_W-1:0]  seg_last  [NSEG];
   logic signed [plist_pkg::VALUE_W-1:0]  seg_rd    [NSEG];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;
   assign sweep_done   = (sweep_ff == SW_W'(NSEG));

   // Decode the held request against the current entry count
   assign pos_x = CW'(pos_ff);
   assign cnt_x = CW'(count_ff);

   always_comb begin
      status_c = plist_pkg::STATUS_OK;
      count_c  = count_ff;
      up_c     = 1'b0;
      down_c   = 1'b0;
      write_c  = 1'b0;
      read_c   = 1'b0;
      unique case (kind_ff)
         plist_pkg::KIND_INSERT: begin
            if (pos_x > cnt_x) begin
               status_c = plist_pkg::STATUS_BAD_POS;
            end else if (cnt_x == CW'(CAPACITY)) begin
               status_c = plist_pkg::STATUS_FULL;
            end else begin
               up_c    = 1'b1;
               count_c = count_ff + 1'b1;
            end
         end
         plist_pkg::KIND_REMOVE: begin
            if (pos_x >= cnt_x) begin
               status_c = plist_pkg::STATUS_BAD_POS;
            end else begin
               down_c  = 1'b1;
               count_c = count_ff - 1'b1;
            end
         end
         plist_pkg::KIND_READ: begin
            if (pos_x >= cnt_x) begin
               status_c = plist_pkg::STATUS_BAD_POS;
            end else begin
               read_c = 1'b1;
            end
         end
         plist_pkg::KIND_OVERWRITE: begin
            if (pos_x >= cnt_x) begin
               status_c = plist_pkg::STATUS_BAD_POS;
            end else begin
               write_c = 1'b1;
            end
         end
         plist_pkg::KIND_CLEAR: begin
            count_c = '0;
         end
         default: begin
            status_c = plist_pkg::STATUS_BAD_POS;
         end
      endcase
   end

   assign load_exec  = (state_ff == S_EXEC) && slot_free && !read_c;
   assign load_sweep = (state_ff == S_SWEEP) && sweep_done && slot_free;

   // Broadcast control to the cell chain
   assign ctrl.shift_up   = load_exec && up_c;
   assign ctrl.shift_down = load_exec && down_c;
   assign ctrl.write      = load_exec && write_c;
   assign ctrl.read_en    = (state_ff == S_SWEEP);
   assign ctrl.pos        = pos_ff;
   assign ctrl.value      = value_ff;

   // Cell chain, split into runs with a registered read bus
   for (genvar s = 0; s < NSEG; s++) begin : g_seg
      localparam int unsigned BASE_S = s * plist_pkg::SEG_LEN;
      localparam int unsigned LEN_S  = (s == NSEG - 1) ? (CAPACITY - BASE_S)
                                                       : plist_pkg::SEG_LEN;
      logic signed [plist_pkg::VALUE_W-1:0] left_s;
      logic signed [plist_pkg::VALUE_W-1:0] right_s;
      logic signed [plist_pkg::VALUE_W-1:0] rd_s;

      if (s == 0) begin : g_head
         assign left_s = value_ff;
         assign rd_s   = '0;
      end else begin : g_body
         assign left_s = seg_last[s-1];
         assign rd_s   = seg_rd[s-1];
      end

      if (s == NSEG - 1) begin : g_tail
         assign right_s = seg_last[s];
      end else begin : g_next
         assign right_s = seg_first[s+1];
      end

      plist_seg #(
         .BASE (BASE_S),
         .LEN  (LEN_S)
      ) u_seg (
         .clock     (clock),
         .ctrl      (ctrl),
         .left_in   (left_s),
         .right_in  (right_s),
         .rd_in     (rd_s),
         .first_out (seg_first[s]),
         .last_out  (seg_last[s]),
         .rd_out    (seg_rd[s])
      );
   end

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      sweep_in = sweep_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (slot_free) begin
               if (read_c) begin
                  state_in = S_SWEEP;
                  sweep_in = '0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_SWEEP: begin
            if (!sweep_done) begin
               sweep_in = sweep_ff + 1'b1;
            end else if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Load the response register, or drop it once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (load_exec) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = '0;
         rsp_status_in = status_c;
         rsp_count_in  = count_c;
      end else if (load_sweep) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = seg_rd[NSEG-1];
         rsp_status_in = plist_pkg::STATUS_OK;
         rsp_count_in  = count_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   assign count_in = load_exec ? count_c : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request and response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_ch.kind;
         pos_ff   <= req_ch.position;
         value_ff <= req_ch.value;
      end
      sweep_ff      <= sweep_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.read_value  = rsp_value_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.entry_count = plist_pkg::COUNT_W'(rsp_count_ff);
   assign rsp_ch.is_empty    = (rsp_count_ff == '0);

   // A full status is only reported when the list really is at capacity
   `PLE_ASSERT_SAME(a_full_at_cap, clock, reset,
      load_exec && (status_c == plist_pkg::STATUS_FULL), count_ff == CNT_W'(CAPACITY))
   // Cells only shift or load while a request executes
   `PLE_ASSERT_SAME(a_shift_in_exec, clock, reset,
      ctrl.shift_up || ctrl.shift_down || ctrl.write, state_ff == S_EXEC)
   // The entry count moves only when a non-read result is loaded
   `PLE_ASSERT_NEXT(a_count_hold, clock, reset, !load_exec, $stable(count_ff))
   // A read result leaves the chain only after the full sweep
   `PLE_ASSERT_SAME(a_sweep_len, clock, reset, load_sweep, sweep_ff == SW_W'(NSEG))

endmodule

`default_nettype wire

// ----- rtl/plist_cell.sv -----
// One list cell: holds a single entry and shifts, loads or holds it each cycle.
// Depends on plist_pkg for the control struct and widths.
`default_nettype none

module plist_cell #(
   parameter int unsigned IDX = 0
) (
   input  wire                                   clock,
   input  wire plist_pkg::cell_ctrl_type         ctrl,
   input  wire signed [plist_pkg::VALUE_W-1:0]   left_in,
   input  wire signed [plist_pkg::VALUE_W-1:0]   right_in,
   input  wire signed [plist_pkg::VALUE_W-1:0]   rd_in,
   output logic signed [plist_pkg::VALUE_W-1:0]  entry_out,
   output logic signed [plist_pkg::VALUE_W-1:0]  rd_out
);

   localparam int unsigned IDX_W = (IDX > 0) ? $clog2(IDX + 1) : 1;
   localparam int unsigned CW    = (IDX_W > plist_pkg::POS_W) ? IDX_W : plist_pkg::POS_W;
   localparam logic [CW-1:0] IDX_C = CW'(IDX);

   logic signed [plist_pkg::VALUE_W-1:0] entry_ff;
   logic signed [plist_pkg::VALUE_W-1:0] entry_in;
   logic [CW-1:0]                        pos_x;
   logic                                 at_pos;
   logic                                 above_pos;

   assign pos_x     = CW'(ctrl.pos);
   assign at_pos    = (IDX_C == pos_x);
   assign above_pos = (IDX_C > pos_x);

   // Take the left neighbor on insert, the right neighbor on remove, or the new value
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift_up) begin
         if (above_pos) begin
            entry_in = left_in;
         end else if (at_pos) begin
            entry_in = ctrl.value;
         end
      end else if (ctrl.shift_down) begin
         if (above_pos || at_pos) begin
            entry_in = right_in;
         end
      end else if (ctrl.write && at_pos) begin
         entry_in = ctrl.value;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Drive the read bus when this cell is addressed, else pass it along
   assign rd_out    = (ctrl.read_en && at_pos) ? entry_ff : rd_in;
   assign entry_out = entry_ff;

endmodule

`default_nettype wire

// ----- rtl/plist_seg.sv -----
// A run of list cells with a register on the outgoing read bus.
// Depends on plist_pkg and plist_cell.
`default_nettype none

module plist_seg #(
   parameter int unsigned BASE = 0,
   parameter int unsigned LEN  = plist_pkg::SEG_LEN
) (
   input  wire                                   clock,
   input  wire plist_pkg::cell_ctrl_type         ctrl,
   input  wire signed [plist_pkg::VALUE_W-1:0]   left_in,
   input  wire signed [plist_pkg::VALUE_W-1:0]   right_in,
   input  wire signed [plist_pkg::VALUE_W-1:0]   rd_in,
   output logic signed [plist_pkg::VALUE_W-1:0]  first_out,
   output logic signed [plist_pkg::VALUE_W-1:0]  last_out,
   output logic signed [plist_pkg::VALUE_W-1:0]  rd_out
);

   logic signed [plist_pkg::VALUE_W-1:0] entry [LEN];
   logic signed [plist_pkg::VALUE_W-1:0] rd    [LEN];
   logic signed [plist_pkg::VALUE_W-1:0] rd_ff;

   // Chain the cells: entries pass between neighbors, read bus runs low to high
   for (genvar i = 0; i < LEN; i++) begin : g_cell
      logic signed [plist_pkg::VALUE_W-1:0] left_c;
      logic signed [plist_pkg::VALUE_W-1:0] right_c;
      logic signed [plist_pkg::VALUE_W-1:0] rd_c;

      if (i == 0) begin : g_first
         assign left_c = left_in;
         assign rd_c   = rd_in;
      end else begin : g_inner
         assign left_c = entry[i-1];
         assign rd_c   = rd[i-1];
      end

      if (i == LEN - 1) begin : g_last
         assign right_c = right_in;
      end else begin : g_mid
         assign right_c = entry[i+1];
      end

      plist_cell #(
         .IDX (BASE + i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .left_in   (left_c),
         .right_in  (right_c),
         .rd_in     (rd_c),
         .entry_out (entry[i]),
         .rd_out    (rd[i])
      );
   end

   // Register the read bus at the end of the run
   always_ff @(posedge clock) begin
      rd_ff <= rd[LEN-1];
   end

   assign first_out = entry[0];
   assign last_out  = entry[LEN-1];
   assign rd_out    = rd_ff;

endmodule

`default_nettype wire
